// File: design/sms_pkg.sv
// ----------------------------------------------------------------------------
// SPI master byte shifter package
// Request codes, queue word layout and transfer modes shared by the block.
// ----------------------------------------------------------------------------
package sms_pkg;

    // Request codes on the command channel.
    localparam logic [2:0] REQ_TICK     = 3'd0;
    localparam logic [2:0] REQ_SELECT   = 3'd1;
    localparam logic [2:0] REQ_DESELECT = 3'd2;
    localparam logic [2:0] REQ_WRITE    = 3'd3;
    localparam logic [2:0] REQ_READ     = 3'd4;
    localparam logic [2:0] REQ_READ_ID  = 3'd5;

    // JEDEC read-ID opcode.
    localparam logic [7:0] JEDEC_READ_ID = 8'h9F;

    // Depth of the queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;

    // Classified operation handed from the front to the back.
    typedef enum logic [2:0] {
        OP_TICK,
        OP_SELECT,
        OP_DESELECT,
        OP_WRITE,
        OP_READ,
        OP_READ_ID,
        OP_INVALID
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] tx_byte;
        logic       miso_level;
    } q_word_t;

    // Transfer mode of the shifter.
    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_WRITE,
        MODE_READ,
        MODE_ID_CMD,
        MODE_ID_READ
    } mode_t;

endpackage

// File: design/sms_if.sv
// ----------------------------------------------------------------------------
// SPI master byte shifter channels
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
interface sms_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] req_type;
    logic [7:0] tx_byte;
    logic       miso_level;

    modport source (output valid, output req_type, output tx_byte, output miso_level,
                    input ready);
    modport sink (input valid, input req_type, input tx_byte, input miso_level,
                  output ready);
endinterface

interface sms_res_if;
    logic        valid;
    logic        ready;
    logic        sclk;
    logic        mosi;
    logic        cs_n;
    logic [31:0] rx_word;
    logic        done_res;
    logic        busy_res;
    logic        rejected;

    modport source (output valid, output sclk, output mosi, output cs_n, output rx_word,
                    output done_res, output busy_res, output rejected, input ready);
    modport sink (input valid, input sclk, input mosi, input cs_n, input rx_word,
                  input done_res, input busy_res, input rejected, output ready);
endinterface

// File: design/sms_front.sv
// ----------------------------------------------------------------------------
// SPI master byte shifter front
// Accepts request words, classifies the request code and stages the word.
// ----------------------------------------------------------------------------
module sms_front (
    input  logic             clk,
    input  logic             rst_n,
    sms_req_if.sink          req,
    output sms_pkg::q_word_t q_word,
    output logic             q_push,
    input  logic             q_full
);
    import sms_pkg::*;

    logic    stage_valid_reg;
    q_word_t stage_reg;
    op_t     op_class;
    logic    take;

    // Map the raw request code onto an operation; unused codes are invalid.
    always_comb
    begin
        unique case (req.req_type)
            REQ_TICK:     op_class = OP_TICK;
            REQ_SELECT:   op_class = OP_SELECT;
            REQ_DESELECT: op_class = OP_DESELECT;
            REQ_WRITE:    op_class = OP_WRITE;
            REQ_READ:     op_class = OP_READ;
            REQ_READ_ID:  op_class = OP_READ_ID;
            default:      op_class = OP_INVALID;
        endcase
    end

    // The stage frees up whenever its word moves into the queue.
    assign q_push    = stage_valid_reg && !q_full;
    assign req.ready = !stage_valid_reg || !q_full;
    assign take      = req.valid && req.ready;
    assign q_word    = stage_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            stage_valid_reg <= 1'b1;
        end
        else if (q_push)
        begin
            stage_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            stage_reg.op         <= op_class;
            stage_reg.tx_byte    <= req.tx_byte;
            stage_reg.miso_level <= req.miso_level;
        end
    end

endmodule

// File: design/sms_queue.sv
// ----------------------------------------------------------------------------
// SPI master byte shifter queue
// Short first-in first-out buffer between the front and the back.
// ----------------------------------------------------------------------------
module sms_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  sms_pkg::q_word_t push_word,
    input  logic             push,
    output logic             full,
    output sms_pkg::q_word_t head_word,
    output logic             head_valid,
    input  logic             head_ready
);
    import sms_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    q_word_t          mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             pop;
    logic             do_push;

    assign full       = (count_reg == FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head_word  = mem[rd_ptr_reg];
    assign pop        = head_valid && head_ready;
    assign do_push    = push && !full;

    // Pointers wrap at the queue depth.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_word;
        end
    end

endmodule

// File: design/sms_back.sv
// ----------------------------------------------------------------------------
// SPI master byte shifter back
// Runs the shifter state for each queued word and registers the result word.
// ----------------------------------------------------------------------------
module sms_back #(
    parameter int ID_BYTES = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  sms_pkg::q_word_t head_word,
    input  logic             head_valid,
    output logic             head_ready,
    sms_res_if.source        res
);
    import sms_pkg::*;

    localparam int ID_COUNT = (ID_BYTES < 1) ? 1 : ((ID_BYTES > 4) ? 4 : ID_BYTES);
    localparam logic [2:0] ID_LAST = 3'(ID_COUNT);
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    mode_t       mode_reg, mode_next;
    logic        phase_reg, phase_next;
    logic [3:0]  bit_cnt_reg, bit_cnt_next;
    logic [2:0]  byte_cnt_reg, byte_cnt_next;
    logic [7:0]  out_shift_reg, out_shift_next;
    logic [31:0] in_shift_reg, in_shift_next;
    logic        sclk_reg, sclk_next;
    logic        mosi_reg, mosi_next;
    logic        cs_reg, cs_next;
    logic        done, rejected;
    logic        res_valid_reg;
    logic        pop;
    logic        reading;
    logic [1:0]  lane;
    logic [3:0]  bit_inc;
    logic [2:0]  byte_inc;
    logic [31:0] sampled;

    assign pop        = head_valid && (!res_valid_reg || res.ready);
    assign head_ready = !res_valid_reg || res.ready;

    // Shift the MISO bit into the selected byte lane of the receive word.
    assign reading  = (mode_reg == MODE_READ) || (mode_reg == MODE_ID_READ);
    assign lane     = (mode_reg == MODE_ID_READ) ? byte_cnt_reg[1:0] : 2'd0;
    assign bit_inc  = bit_cnt_reg + 4'd1;
    assign byte_inc = byte_cnt_reg + 3'd1;

    always_comb
    begin
        sampled = in_shift_reg;
        for (int l = 0; l < 4; l++)
        begin
            if (lane == 2'(l))
            begin
                sampled[8*l +: 8] = {in_shift_reg[8*l +: 7], head_word.miso_level};
            end
        end
    end

    // Next state for one word.
    always_comb
    begin
        mode_next      = mode_reg;
        phase_next     = phase_reg;
        bit_cnt_next   = bit_cnt_reg;
        byte_cnt_next  = byte_cnt_reg;
        out_shift_next = out_shift_reg;
        in_shift_next  = in_shift_reg;
        sclk_next      = sclk_reg;
        mosi_next      = mosi_reg;
        cs_next        = cs_reg;
        done           = 1'b0;
        rejected       = 1'b0;

        case (head_word.op)
            OP_TICK:
            begin
                if (mode_reg != MODE_IDLE)
                begin
                    if (!phase_reg)
                    begin
                        // Low phase: drive the next bit or sample MISO.
                        sclk_next  = 1'b0;
                        phase_next = 1'b1;
                        if (reading)
                        begin
                            in_shift_next = sampled;
                        end
                        else
                        begin
                            mosi_next      = out_shift_reg[7];
                            out_shift_next = {out_shift_reg[6:0], 1'b0};
                        end
                    end
                    else
                    begin
                        // High phase: raise the clock and count the bit.
                        sclk_next    = 1'b1;
                        phase_next   = 1'b0;
                        bit_cnt_next = bit_inc;
                        if (bit_inc == BITS_PER_BYTE)
                        begin
                            bit_cnt_next = 4'd0;
                            if (mode_reg == MODE_ID_CMD)
                            begin
                                mode_next     = MODE_ID_READ;
                                byte_cnt_next = 3'd0;
                            end
                            else if ((mode_reg == MODE_ID_READ) && (byte_inc < ID_LAST))
                            begin
                                byte_cnt_next = byte_inc;
                            end
                            else
                            begin
                                if (mode_reg == MODE_ID_READ)
                                begin
                                    cs_next = 1'b1;
                                end
                                mode_next     = MODE_IDLE;
                                byte_cnt_next = 3'd0;
                                done          = 1'b1;
                            end
                        end
                    end
                end
            end
            OP_INVALID:
            begin
                rejected = 1'b1;
            end
            default:
            begin
                if (mode_reg != MODE_IDLE)
                begin
                    rejected = 1'b1;
                end
                else
                begin
                    phase_next    = 1'b0;
                    bit_cnt_next  = 4'd0;
                    byte_cnt_next = 3'd0;
                    case (head_word.op)
                        OP_SELECT:
                        begin
                            cs_next = 1'b0;
                        end
                        OP_DESELECT:
                        begin
                            cs_next = 1'b1;
                        end
                        OP_WRITE:
                        begin
                            out_shift_next = head_word.tx_byte;
                            mode_next      = MODE_WRITE;
                        end
                        OP_READ:
                        begin
                            in_shift_next = 32'd0;
                            mode_next     = MODE_READ;
                        end
                        default:
                        begin
                            cs_next        = 1'b0;
                            out_shift_next = JEDEC_READ_ID;
                            in_shift_next  = 32'd0;
                            mode_next      = MODE_ID_CMD;
                        end
                    endcase
                end
            end
        endcase
    end

    // Transfer mode register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
        end
        else if (pop)
        begin
            mode_reg <= mode_next;
        end
    end

    // Shifter datapath and pin levels.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= 1'b0;
            bit_cnt_reg   <= 4'd0;
            byte_cnt_reg  <= 3'd0;
            out_shift_reg <= 8'd0;
            in_shift_reg  <= 32'd0;
            sclk_reg      <= 1'b0;
            mosi_reg      <= 1'b0;
            cs_reg        <= 1'b1;
        end
        else if (pop)
        begin
            phase_reg     <= phase_next;
            bit_cnt_reg   <= bit_cnt_next;
            byte_cnt_reg  <= byte_cnt_next;
            out_shift_reg <= out_shift_next;
            in_shift_reg  <= in_shift_next;
            sclk_reg      <= sclk_next;
            mosi_reg      <= mosi_next;
            cs_reg        <= cs_next;
        end
    end

    // Result word register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            res.sclk     <= sclk_next;
            res.mosi     <= mosi_next;
            res.cs_n     <= cs_next;
            res.rx_word  <= in_shift_next;
            res.done_res <= done;
            res.busy_res <= (mode_next != MODE_IDLE);
            res.rejected <= rejected;
        end
    end

    assign res.valid = res_valid_reg;

endmodule

// File: design/spi_master_byte_shifter.sv
// ----------------------------------------------------------------------------
// SPI master byte shifter
// Mode 0 SPI master with byte write, byte read and JEDEC read-ID sequences.
// ----------------------------------------------------------------------------
// Usage: the req channel carries request words (tick, select, deselect,
// write byte, read byte, read ID). A tick is one half-bit period and carries
// the sampled MISO level. Each request word gives exactly one result word on
// the res channel with the pin levels after that word, the receive word and
// the done, busy and rejected flags. Commands that arrive during a transfer
// are rejected and leave the state alone.
// From acceptance to the result being offered, the word is written into the
// front stage, then into the queue and then into the result register.
// Throughput is one word per cycle while the receiver takes results; the
// back part updates the shifter state once per word.
// When the receiver stalls, the result register holds its word, the queue
// and the front stage fill, and then req.ready drops; no word is lost.
// Reset empties the front stage, the queue and the result register, sets the
// shifter idle with the clock and MOSI low and chip select high.
// ----------------------------------------------------------------------------
module spi_master_byte_shifter #(
    parameter int ID_BYTES = 4
) (
    input  logic      clk,
    input  logic      rst_n,
    sms_req_if.sink   req,
    sms_res_if.source res
);
    import sms_pkg::*;

    q_word_t stage_word;
    q_word_t head_word;
    logic    q_push;
    logic    q_full;
    logic    head_valid;
    logic    head_ready;

    sms_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .q_word (stage_word),
        .q_push (q_push),
        .q_full (q_full)
    );

    sms_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_word  (stage_word),
        .push       (q_push),
        .full       (q_full),
        .head_word  (head_word),
        .head_valid (head_valid),
        .head_ready (head_ready)
    );

    sms_back #(
        .ID_BYTES (ID_BYTES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_word  (head_word),
        .head_valid (head_valid),
        .head_ready (head_ready),
        .res        (res)
    );

endmodule
